// ===== rtl/core/bdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// operation codes and status codes shared by the bounded deque modules
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int FUNC_WIDTH = 3;

   localparam logic [FUNC_WIDTH-1:0] FUNC_PUSH_BACK  = 3'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_PUSH_FRONT = 3'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_POP_BACK   = 3'd3;
   localparam logic [FUNC_WIDTH-1:0] FUNC_READ_AT    = 3'd4;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

endpackage

// ===== rtl/core/bounded_deque_with_index_read_unit.sv =====
// push requests and refused or failed requests: response in the cycle after accept
// pop and indexed read requests: the entry memory's registered read data is
//   taken into the response register, and new requests stall meanwhile
// throughput: 1 request per cycle for pushes and errors while no response stall
// reset: head pointer and count cleared, queue empty; memory is not cleared
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_index_read_unit
// bounded double-ended queue in a ring buffer with indexed read
// ----------------------------------------------------------------------------
module bounded_deque_with_index_read_unit #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [bdq_pkg::FUNC_WIDTH-1:0]   req_func,
   input  logic [DATA_WIDTH-1:0]            req_push_value,
   input  logic [$clog2(DEPTH)-1:0]         req_position,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [DATA_WIDTH-1:0]            rsp_result_value,
   output logic [1:0]                       rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]       rsp_entry_count
);

   logic                       mem_wr_en;
   logic [$clog2(DEPTH)-1:0]   mem_wr_addr;
   logic [DATA_WIDTH-1:0]      mem_wr_data;
   logic                       mem_rd_en;
   logic [$clog2(DEPTH)-1:0]   mem_rd_addr;
   logic [DATA_WIDTH-1:0]      mem_rd_data;

   bdq_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   bdq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_push_value   (req_push_value),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_en        (mem_rd_en),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data)
   );

endmodule

// ===== rtl/core/bdq_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_mem
// entry storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module bdq_mem #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0]         wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0]         rd_data
);

   logic [DATA_WIDTH-1:0] store_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bdq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctrl
// head pointer, occupancy, request decode, memory sequencing and response
// register
// ----------------------------------------------------------------------------
module bdq_ctrl #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [bdq_pkg::FUNC_WIDTH-1:0]   req_func,
   input  logic [DATA_WIDTH-1:0]            req_push_value,
   input  logic [$clog2(DEPTH)-1:0]         req_position,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [DATA_WIDTH-1:0]            rsp_result_value,
   output logic [1:0]                       rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]       rsp_entry_count,
   output logic                             mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]         mem_wr_addr,
   output logic [DATA_WIDTH-1:0]            mem_wr_data,
   output logic                             mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]         mem_rd_addr,
   input  logic [DATA_WIDTH-1:0]            mem_rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type             state_ff;
   logic [AW-1:0]         head_ff;
   logic [CW-1:0]         count_ff;
   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] rsp_value_ff;
   bdq_pkg::status_type   rsp_status_ff;
   logic [CW-1:0]         rsp_count_ff;

   logic                  accept;
   logic                  full;
   logic                  empty;
   logic [CW-1:0]         count_dec;
   logic [AW-1:0]         head_dec;
   logic [AW-1:0]         offset;
   logic [AW:0]           sum;
   logic [AW-1:0]         slot;
   logic                  act_wr;
   logic                  act_rd;
   logic [AW-1:0]         act_addr;
   logic [AW-1:0]         head_in;
   logic [CW-1:0]         count_in;
   bdq_pkg::status_type   status_in;

   assign req_stall = (state_ff == S_READ) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == FULL_C);
   assign empty     = (count_ff == '0);
   assign count_dec = count_ff - 1'b1;
   assign head_dec  = (head_ff == '0) ? LAST_SLOT : head_ff - 1'b1;

   // slot = (head + offset) mod depth, offset below depth when used
   always_comb begin
      case (req_func)
         bdq_pkg::FUNC_PUSH_BACK: offset = count_ff[AW-1:0];
         bdq_pkg::FUNC_POP_FRONT: offset = AW'(1);
         bdq_pkg::FUNC_POP_BACK:  offset = count_dec[AW-1:0];
         bdq_pkg::FUNC_READ_AT:   offset = req_position;
         default:                 offset = '0;
      endcase
      sum  = {1'b0, head_ff} + {1'b0, offset};
      slot = (sum >= DEPTH_W) ? AW'(sum - DEPTH_W) : sum[AW-1:0];
   end

   always_comb begin
      act_wr    = 1'b0;
      act_rd    = 1'b0;
      act_addr  = slot;
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = bdq_pkg::ST_OK;
      case (req_func)
         bdq_pkg::FUNC_PUSH_BACK: begin
            if (full) begin
               status_in = bdq_pkg::ST_FULL;
            end else begin
               act_wr   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         bdq_pkg::FUNC_PUSH_FRONT: begin
            if (full) begin
               status_in = bdq_pkg::ST_FULL;
            end else begin
               act_wr   = 1'b1;
               act_addr = head_dec;
               head_in  = head_dec;
               count_in = count_ff + 1'b1;
            end
         end
         bdq_pkg::FUNC_POP_FRONT: begin
            if (empty) begin
               status_in = bdq_pkg::ST_EMPTY;
            end else begin
               act_rd   = 1'b1;
               act_addr = head_ff;
               head_in  = slot;
               count_in = count_dec;
            end
         end
         bdq_pkg::FUNC_POP_BACK: begin
            if (empty) begin
               status_in = bdq_pkg::ST_EMPTY;
            end else begin
               act_rd   = 1'b1;
               count_in = count_dec;
            end
         end
         bdq_pkg::FUNC_READ_AT: begin
            if (CW'(req_position) >= count_ff) begin
               status_in = bdq_pkg::ST_RANGE;
            end else begin
               act_rd = 1'b1;
            end
         end
         default: begin
            status_in = bdq_pkg::ST_RANGE;
         end
      endcase
   end

   assign mem_wr_en   = accept && act_wr;
   assign mem_wr_addr = act_addr;
   assign mem_wr_data = req_push_value;
   assign mem_rd_en   = accept && act_rd;
   assign mem_rd_addr = act_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  head_ff       <= head_in;
                  count_ff      <= count_in;
                  rsp_status_ff <= status_in;
                  rsp_count_ff  <= count_in;
                  rsp_value_ff  <= '0;
                  rsp_valid_ff  <= !act_rd;
                  if (act_rd) begin
                     state_ff <= S_READ;
                  end
               end else if (rsp_valid_ff && !rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            S_READ: begin
               // memory data for the accepted pop or read arrives now
               rsp_value_ff <= mem_rd_data;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule
